// ===== hw/rtl/echo_frame_ranging_parser_core_defines.svh =====
// Assertion macros for the echo frame ranging parser.
`ifndef ECHO_FRAME_RANGING_PARSER_CORE_DEFINES_SVH
`define ECHO_FRAME_RANGING_PARSER_CORE_DEFINES_SVH

// Checked outside reset.
`define EFRP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define EFRP_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/efrp_pkg.sv =====
// Shared types and constants for the echo frame ranging parser.
package efrp_pkg;

  localparam logic [4:0]  SENSOR_COUNT_RST   = 5'd14;
  localparam logic [23:0] TIME_SCALE_RST     = 24'd888889;
  localparam logic [19:0] DISTANCE_SCALE_RST = 20'd151240;

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  typedef enum logic [1:0] {
    CFG_SENSOR_COUNT   = 2'd0,
    CFG_TIME_SCALE     = 2'd1,
    CFG_DISTANCE_SCALE = 2'd2
  } cfg_idx_t;

  typedef enum logic [1:0] {
    KIND_SEQ  = 2'd0,
    KIND_HDR  = 2'd1,
    KIND_READ = 2'd2
  } kind_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  seq;
    logic [3:0]  sensor;
    logic [3:0]  count;
    logic [3:0]  index;
    logic [15:0] ticks;
    logic        neg;
    logic [15:0] mag;
    logic        frame_done;
  } item_t;

endpackage

// ===== hw/rtl/echo_frame_ranging_parser_core.sv =====
// Top level of the echo frame ranging parser: config registers, parser, queue, scaler.
//
//  channel | handshake               | payload
//  --------+-------------------------+----------------------------------------
//  in      | in_push / in_full       | in_rx_byte
//  out     | out_pop / out_empty     | kind, ids, counts, ticks, time, distance
//  cfg     | cfg_valid / cfg_ready   | cfg_index, cfg_data
//
// One byte is taken per cycle while the four-entry item queue has room.
// A byte's item goes into the queue, then the multiply stage, then the result register.
// Output stalls back up through the two pipeline stages, then the queue.
// Synchronous active-low reset; no clearing pass.
`include "echo_frame_ranging_parser_core_defines.svh"

module echo_frame_ranging_parser_core
  import efrp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [7:0]  in_rx_byte,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_sequence_number,
  output logic [3:0]  out_sensor_id,
  output logic [3:0]  out_reading_count,
  output logic [3:0]  out_reading_index,
  output logic [15:0] out_timer_ticks,
  output logic [31:0] out_time_ns,
  output logic signed [28:0] out_distance_um,
  output logic        out_frame_done,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_data
);

  logic [4:0]  sensor_count_r;
  logic [23:0] time_scale_r;
  logic [19:0] distance_scale_r;

  logic  byte_accept;
  logic  f_push;
  item_t f_item;
  logic  q_full;
  logic  q_empty;
  logic  q_pop;
  item_t q_item;
  logic  res_valid;
  item_t res_item;

  assign cfg_ready   = 1'b1;
  assign in_full     = q_full;
  assign byte_accept = in_push && !q_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sensor_count_r   <= SENSOR_COUNT_RST;
      time_scale_r     <= TIME_SCALE_RST;
      distance_scale_r <= DISTANCE_SCALE_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_SENSOR_COUNT:   sensor_count_r   <= cfg_data[4:0];
        CFG_TIME_SCALE:     time_scale_r     <= cfg_data;
        CFG_DISTANCE_SCALE: distance_scale_r <= cfg_data[19:0];
        default:            sensor_count_r   <= sensor_count_r;
      endcase
    end
  end

  efrp_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .byte_accept  (byte_accept),
    .byte_in      (in_rx_byte),
    .sensor_count (sensor_count_r),
    .item_push    (f_push),
    .item         (f_item)
  );

  efrp_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (f_push),
    .wr_item (f_item),
    .full    (q_full),
    .pop     (q_pop),
    .empty   (q_empty),
    .rd_item (q_item)
  );

  efrp_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_empty         (q_empty),
    .q_item          (q_item),
    .q_pop           (q_pop),
    .time_scale      (time_scale_r),
    .distance_scale  (distance_scale_r),
    .res_valid       (res_valid),
    .res_pop         (out_pop),
    .res_item        (res_item),
    .res_time_ns     (out_time_ns),
    .res_distance_um (out_distance_um)
  );

  assign out_empty           = !res_valid;
  assign out_kind            = res_item.kind;
  assign out_sequence_number = res_item.seq;
  assign out_sensor_id       = res_item.sensor;
  assign out_reading_count   = res_item.count;
  assign out_reading_index   = res_item.index;
  assign out_timer_ticks     = res_item.ticks;
  assign out_frame_done      = res_item.frame_done;

  `EFRP_ASSERT(a_nonread_zero, (!out_empty && out_kind != KIND_READ) |-> (out_time_ns == 32'd0 && out_distance_um == 29'sd0), "non-reading result carries scaled values")
  `EFRP_ASSERT(a_base_zero, (!out_empty && out_kind == KIND_READ && out_reading_index == 4'd0) |-> (out_distance_um == 29'sd0), "base reading with nonzero distance")
  `EFRP_ASSERT_ALWAYS(a_rst_empty, !rst_n |=> out_empty, "result present right after reset")

endmodule

// ===== hw/rtl/efrp_front.sv =====
// Byte parser: tracks frame position and emits classified items.
module efrp_front
  import efrp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       byte_accept,
  input  logic [7:0] byte_in,
  input  logic [4:0] sensor_count,
  output logic       item_push,
  output item_t      item
);

  typedef enum logic [1:0] {
    PH_SEQ  = 2'd0,
    PH_HDR  = 2'd1,
    PH_HIGH = 2'd2,
    PH_LOW  = 2'd3
  } phase_t;

  phase_t      phase_r;
  logic [4:0]  pos_r;
  logic [3:0]  sensor_r;
  logic [3:0]  count_r;
  logic [3:0]  rdpos_r;
  logic [7:0]  hold_r;
  logic [15:0] base_r;
  logic [7:0]  seq_r;

  logic [15:0] ticks;
  logic [4:0]  pos_inc;
  logic [4:0]  limit;
  logic        grp_last;
  logic [3:0]  rdpos_inc;
  logic        rd_last;

  always_comb begin
    ticks     = {hold_r, byte_in};
    pos_inc   = pos_r + 5'd1;
    limit     = (sensor_count == 5'd0) ? 5'd1 : sensor_count;
    grp_last  = pos_inc >= limit;
    rdpos_inc = rdpos_r + 4'd1;
    rd_last   = rdpos_inc >= count_r;
  end

  always_comb begin
    item       = '0;
    item.seq   = seq_r;
    item_push  = 1'b0;
    unique case (phase_r)
      PH_SEQ: begin
        item.kind = KIND_SEQ;
        item.seq  = byte_in;
        item_push = byte_accept;
      end
      PH_HDR: begin
        item.kind       = KIND_HDR;
        item.sensor     = byte_in[7:4];
        item.count      = byte_in[3:0];
        item.frame_done = (byte_in[3:0] == 4'd0) && grp_last;
        item_push       = byte_accept;
      end
      PH_HIGH: begin
        item_push = 1'b0;
      end
      PH_LOW: begin
        item.kind       = KIND_READ;
        item.sensor     = sensor_r;
        item.count      = count_r;
        item.index      = rdpos_r;
        item.ticks      = ticks;
        item.frame_done = rd_last && grp_last;
        if (rdpos_r == 4'd0) begin
          item.mag = '0;
        end else if (ticks >= base_r) begin
          item.mag = ticks - base_r;
        end else begin
          item.neg = 1'b1;
          item.mag = base_r - ticks;
        end
        item_push = byte_accept;
      end
      default: item_push = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_SEQ;
      pos_r    <= '0;
      sensor_r <= '0;
      count_r  <= '0;
      rdpos_r  <= '0;
      hold_r   <= '0;
      base_r   <= '0;
      seq_r    <= '0;
    end else if (byte_accept) begin
      unique case (phase_r)
        PH_SEQ: begin
          seq_r   <= byte_in;
          pos_r   <= '0;
          rdpos_r <= '0;
          phase_r <= PH_HDR;
        end
        PH_HDR: begin
          sensor_r <= byte_in[7:4];
          count_r  <= byte_in[3:0];
          rdpos_r  <= '0;
          if (byte_in[3:0] == 4'd0) begin
            pos_r   <= grp_last ? 5'd0 : pos_inc;
            phase_r <= grp_last ? PH_SEQ : PH_HDR;
          end else begin
            phase_r <= PH_HIGH;
          end
        end
        PH_HIGH: begin
          hold_r  <= byte_in;
          phase_r <= PH_LOW;
        end
        PH_LOW: begin
          if (rdpos_r == 4'd0) begin
            base_r <= ticks;
          end
          if (rd_last) begin
            rdpos_r <= '0;
            pos_r   <= grp_last ? 5'd0 : pos_inc;
            phase_r <= grp_last ? PH_SEQ : PH_HDR;
          end else begin
            rdpos_r <= rdpos_inc;
            phase_r <= PH_HIGH;
          end
        end
        default: phase_r <= PH_SEQ;
      endcase
    end
  end

endmodule

// ===== hw/rtl/efrp_queue.sv =====
// Short item queue between parser and arithmetic back end.
module efrp_queue
  import efrp_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  item_t wr_item,
  output logic  full,
  input  logic  pop,
  output logic  empty,
  output item_t rd_item
);

  item_t        mem_r [QDEPTH];
  logic [QAW-1:0] wr_ptr_r;
  logic [QAW-1:0] rd_ptr_r;
  logic [QAW:0]   cnt_r;
  logic           do_wr;
  logic           do_rd;

  assign full    = cnt_r == QDEPTH[QAW:0];
  assign empty   = cnt_r == '0;
  assign do_wr   = push && !full;
  assign do_rd   = pop && !empty;
  assign rd_item = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_wr) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_rd) rd_ptr_r <= rd_ptr_r + 1'b1;
      unique case ({do_wr, do_rd})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

// ===== hw/rtl/efrp_back.sv =====
// Two-stage scaling pipeline: multiply, then shift and sign, into the result register.
module efrp_back
  import efrp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_empty,
  input  item_t       q_item,
  output logic        q_pop,
  input  logic [23:0] time_scale,
  input  logic [19:0] distance_scale,
  output logic        res_valid,
  input  logic        res_pop,
  output item_t       res_item,
  output logic [31:0] res_time_ns,
  output logic signed [28:0] res_distance_um
);

  logic        v1_r;
  item_t       it1_r;
  logic [39:0] pt_r;
  logic [35:0] pd_r;

  logic        v2_r;
  item_t       it2_r;
  logic [31:0] t2_r;
  logic [28:0] d2_r;

  logic        s2_ready;
  logic        s1_ready;
  logic [36:0] pd_up;
  logic [28:0] d_nxt;

  assign s2_ready = !v2_r || res_pop;
  assign s1_ready = !v1_r || s2_ready;
  assign q_pop    = !q_empty && s1_ready;

  always_comb begin
    pd_up = {1'b0, pd_r} + 37'd255;
    if (it1_r.neg) begin
      d_nxt = 29'(-pd_up[36:8]);
    end else begin
      d_nxt = {1'b0, pd_r[35:8]};
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready) begin
      it1_r <= q_item;
      pt_r  <= {24'd0, q_item.ticks} * {16'd0, time_scale};
      pd_r  <= {20'd0, q_item.mag} * {16'd0, distance_scale};
    end
    if (s2_ready && v1_r) begin
      it2_r <= it1_r;
      t2_r  <= pt_r[39:8];
      d2_r  <= d_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (s1_ready) v1_r <= q_pop;
      if (s2_ready) v2_r <= v1_r;
    end
  end

  assign res_valid       = v2_r;
  assign res_item        = it2_r;
  assign res_time_ns     = t2_r;
  assign res_distance_um = d2_r;

endmodule

// ===== test/tb.sv =====
// Self-checking testbench for the echo frame ranging parser core.
module tb;
  import efrp_pkg::*;

  typedef enum logic [1:0] {
    AWAIT_SEQ  = 2'd0,
    AWAIT_HDR  = 2'd1,
    AWAIT_HIGH = 2'd2,
    AWAIT_LOW  = 2'd3
  } parse_phase_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  seq;
    logic [3:0]  sensor;
    logic [3:0]  count;
    logic [3:0]  index;
    logic [15:0] ticks;
    logic [31:0] time_ns;
    logic [28:0] dist_um;
    logic        done;
  } ranging_result_t;

  class ranging_scoreboard;
    logic [4:0]   sensor_count;
    logic [23:0]  time_scale;
    logic [19:0]  distance_scale;
    parse_phase_t phase;
    logic [4:0]   group_pos;
    logic [3:0]   sensor;
    logic [3:0]   count;
    logic [3:0]   read_pos;
    logic [7:0]   high_hold;
    logic [15:0]  base;
    logic [7:0]   seq;
    ranging_result_t expected_results[$];
    int errors;

    function new();
      sensor_count   = SENSOR_COUNT_RST;
      time_scale     = TIME_SCALE_RST;
      distance_scale = DISTANCE_SCALE_RST;
      phase          = AWAIT_SEQ;
      group_pos      = '0;
      sensor         = '0;
      count          = '0;
      read_pos       = '0;
      high_hold      = '0;
      base           = '0;
      seq            = '0;
      errors         = 0;
    endfunction

    function void write_reg(cfg_idx_t idx, logic [23:0] data);
      case (idx)
        CFG_SENSOR_COUNT:   sensor_count = data[4:0];
        CFG_TIME_SCALE:     time_scale = data;
        CFG_DISTANCE_SCALE: distance_scale = data[19:0];
        default: ;
      endcase
    endfunction

    function bit close_group();
      logic [4:0] limit;
      limit = (sensor_count == 5'd0) ? 5'd1 : sensor_count;
      group_pos = group_pos + 5'd1;
      read_pos = '0;
      if (group_pos >= limit) begin
        group_pos = '0;
        phase = AWAIT_SEQ;
        return 1'b1;
      end
      phase = AWAIT_HDR;
      return 1'b0;
    endfunction

    function void note_byte(logic [7:0] b);
      ranging_result_t r;
      logic [15:0] ticks;
      longint d;
      r = '0;
      case (phase)
        AWAIT_SEQ: begin
          seq = b;
          group_pos = '0;
          read_pos = '0;
          phase = AWAIT_HDR;
          r.kind = KIND_SEQ;
          r.seq = seq;
        end
        AWAIT_HDR: begin
          sensor = b[7:4];
          count = b[3:0];
          read_pos = '0;
          r.kind = KIND_HDR;
          r.seq = seq;
          r.sensor = sensor;
          r.count = count;
          if (count == 4'd0) r.done = close_group();
          else phase = AWAIT_HIGH;
        end
        AWAIT_HIGH: begin
          high_hold = b;
          phase = AWAIT_LOW;
          return;
        end
        default: begin
          ticks = {high_hold, b};
          d = 0;
          if (read_pos == 4'd0) base = ticks;
          else d = ((longint'(ticks) - longint'(base)) * longint'(distance_scale)) >>> 8;
          r.kind = KIND_READ;
          r.seq = seq;
          r.sensor = sensor;
          r.count = count;
          r.index = read_pos;
          r.ticks = ticks;
          r.time_ns = 32'((longint'(ticks) * longint'(time_scale)) >> 8);
          r.dist_um = d[28:0];
          read_pos = read_pos + 4'd1;
          if (read_pos >= count) r.done = close_group();
          else phase = AWAIT_HIGH;
        end
      endcase
      expected_results.push_back(r);
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 100) $display("ERROR %0t: %s", $time, msg);
    endtask

    task check_result(ranging_result_t got);
      ranging_result_t want;
      if (expected_results.size() == 0) begin
        report($sformatf("result with no transfer pending: %p", got));
        return;
      end
      want = expected_results.pop_front();
      if (got !== want) report($sformatf("mismatch: got %p expected %p", got, want));
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_push = 1'b0;
  logic        in_full;
  logic [7:0]  in_rx_byte = '0;
  logic        out_empty;
  logic        out_pop = 1'b0;
  logic [1:0]  out_kind;
  logic [7:0]  out_sequence_number;
  logic [3:0]  out_sensor_id;
  logic [3:0]  out_reading_count;
  logic [3:0]  out_reading_index;
  logic [15:0] out_timer_ticks;
  logic [31:0] out_time_ns;
  logic signed [28:0] out_distance_um;
  logic        out_frame_done;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [23:0] cfg_data = '0;

  ranging_scoreboard sb = new();
  int  tx_idle_pct = 31;
  int  rx_idle_pct = 72;
  bit  hold_request = 1'b0;
  bit  hold_taken = 1'b0;
  int  hold_left = 0;
  logic [4:0] cur_sc = SENSOR_COUNT_RST;

  echo_frame_ranging_parser_core dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_push(in_push),
    .in_full(in_full),
    .in_rx_byte(in_rx_byte),
    .out_empty(out_empty),
    .out_pop(out_pop),
    .out_kind(out_kind),
    .out_sequence_number(out_sequence_number),
    .out_sensor_id(out_sensor_id),
    .out_reading_count(out_reading_count),
    .out_reading_index(out_reading_index),
    .out_timer_ticks(out_timer_ticks),
    .out_time_ns(out_time_ns),
    .out_distance_um(out_distance_um),
    .out_frame_done(out_frame_done),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    ranging_result_t got;
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      if (out_pop && !out_empty) begin
        got.kind    = kind_t'(out_kind);
        got.seq     = out_sequence_number;
        got.sensor  = out_sensor_id;
        got.count   = out_reading_count;
        got.index   = out_reading_index;
        got.ticks   = out_timer_ticks;
        got.time_ns = out_time_ns;
        got.dist_um = out_distance_um;
        got.done    = out_frame_done;
        sb.check_result(got);
      end
      if (hold_request && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left = 80;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_pop <= 1'b0;
      end else begin
        out_pop <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  task automatic send_byte(logic [7:0] b);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (in_full) @(posedge clk);
    sb.note_byte(b);
  endtask

  task automatic write_one(cfg_idx_t idx, logic [23:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, data);
  endtask

  task automatic write_regs(logic [4:0] sc, logic [23:0] ts, logic [19:0] ds);
    write_one(CFG_SENSOR_COUNT, {19'($urandom), sc});
    write_one(CFG_TIME_SCALE, ts);
    write_one(CFG_DISTANCE_SCALE, {4'($urandom), ds});
    cfg_valid <= 1'b0;
    cur_sc = sc;
  endtask

  task automatic wait_idle();
    in_push <= 1'b0;
    while (sb.expected_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_ticks(logic [15:0] base_t);
    case ($urandom_range(9))
      0: return 16'h0000;
      1: return 16'hffff;
      2, 3, 4: return base_t + 16'($urandom_range(64)) - 16'd32;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [3:0] pick_count();
    case ($urandom_range(19))
      0, 1: return 4'd0;
      2: return 4'd15;
      default: return 4'($urandom_range(4, 1));
    endcase
  endfunction

  task automatic run_frames(int n_items);
    int sent;
    int groups;
    logic [3:0] cnt;
    logic [15:0] base_t;
    logic [15:0] t;
    sent = 0;
    base_t = '0;
    while (sent < n_items) begin
      if ($urandom_range(99) < 8) begin
        repeat ($urandom_range(3, 1)) begin
          send_byte(8'($urandom));
          sent++;
        end
      end else begin
        send_byte(8'($urandom));
        sent++;
        groups = (cur_sc == 5'd0) ? 1 : int'(cur_sc);
        for (int g = 0; g < groups; g++) begin
          if ($urandom_range(99) < 3) break;
          cnt = pick_count();
          send_byte({4'($urandom), cnt});
          sent++;
          for (int k = 0; k < int'(cnt); k++) begin
            t = pick_ticks(base_t);
            if (k == 0) base_t = t;
            send_byte(t[15:8]);
            send_byte(t[7:0]);
            sent += 2;
          end
        end
      end
    end
  endtask

  initial begin
    logic [7:0] dir_a[$];
    logic [7:0] dir_b[$];
    logic [7:0] dir_c[$];
    logic [4:0] sc_tab[9];
    logic [23:0] ts;
    logic [19:0] ds;
    dir_a = '{8'h5a, 8'h21, 8'h12, 8'h34};
    dir_b = '{8'h00, 8'hff, 8'hf3, 8'h00, 8'h00, 8'hff, 8'hff, 8'h00, 8'h00,
              8'h02, 8'hff, 8'hff, 8'h00, 8'h00};
    dir_c = '{8'h00, 8'h10, 8'hab, 8'h01, 8'h80, 8'h00};
    sc_tab = '{5'd1, 5'd16, 5'd31, 5'd3, 5'd0, 5'd14, 5'd2, 5'd16, 5'd5};

    rst_n <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset register values, then extremes, then zero scales
    foreach (dir_a[i]) send_byte(dir_a[i]);
    wait_idle();
    write_regs(5'd2, 24'hffffff, 20'hfffff);
    foreach (dir_b[i]) send_byte(dir_b[i]);
    wait_idle();
    write_regs(5'd0, 24'h000000, 20'h00000);
    foreach (dir_c[i]) send_byte(dir_c[i]);
    wait_idle();

    for (int p = 0; p < 9; p++) begin
      case (p / 3)
        0: begin tx_idle_pct = 31; rx_idle_pct = 72; end
        1: begin tx_idle_pct = 72; rx_idle_pct = 31; end
        default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
      endcase
      ts = (p == 0) ? 24'hffffff : (p == 3) ? 24'h000000 : 24'($urandom);
      ds = (p == 1) ? 20'hfffff : (p == 4) ? 20'h00000 : 20'($urandom);
      if (p == 5) begin
        ts = TIME_SCALE_RST;
        ds = DISTANCE_SCALE_RST;
      end
      write_regs(sc_tab[p], ts, ds);
      if (p == 7) hold_request = 1'b1;
      run_frames(110);
      wait_idle();
    end

    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.expected_results.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/efrp_pkg.sv
hw/rtl/efrp_front.sv
hw/rtl/efrp_queue.sv
hw/rtl/efrp_back.sv
hw/rtl/echo_frame_ranging_parser_core.sv
test/tb.sv
